/* sv/abm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package abm_pkg;

	localparam int OPND_W       = 16;
	localparam int PROD_W       = 32;
	localparam int BUDGET_W     = 6;
	localparam int CFG_ADDR_W   = 1;
	localparam int DEF_WIDTH_A  = 16;
	localparam int DEF_WIDTH_B  = 16;

	localparam logic [BUDGET_W-1:0]   BUDGET_RESET    = 6'd32;
	localparam logic [CFG_ADDR_W-1:0] REG_STEP_BUDGET = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_PARITY_FLIP = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_HOLD
	} abm_state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_ADD,
		OP_SUB
	} abm_op_t;

	typedef struct packed {
		logic load;      // take a new item into the datapath
		logic step;      // pick one partial product this cycle
		logic add_turn;  // this step may take an add
		logic capture;   // move accumulator into the output register
	} abm_cmd_t;

	typedef struct packed {
		logic lists_empty;  // no add and no subtract left
	} abm_status_t;

endpackage
`default_nettype wire

/* sv/abm_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module abm_datapath import abm_pkg::*; #(
	parameter int WIDTH_A = DEF_WIDTH_A,
	parameter int WIDTH_B = DEF_WIDTH_B
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire abm_cmd_t            cmd,
	output abm_status_t              status,
	input  wire logic [OPND_W-1:0]   operand_a,
	input  wire logic [OPND_W-1:0]   operand_b,
	output logic [PROD_W-1:0]        approx_product
);

	localparam int POS_W = $clog2(WIDTH_A);

	logic signed [PROD_W-1:0]  a_ext;
	logic signed [PROD_W-1:0]  b_ext;
	logic        [WIDTH_A-1:0] a_w;
	logic signed [WIDTH_B-1:0] b_w;
	logic        [WIDTH_A-1:0] adds_q;
	logic        [WIDTH_A-1:0] subs_q;
	logic        [PROD_W-1:0]  b_q;
	logic        [PROD_W-1:0]  acc_q;
	logic        [PROD_W-1:0]  out_q;
	logic        [PROD_W-1:0]  b_shift;
	logic        [WIDTH_A-1:0] sel_mask;
	logic        [WIDTH_A-1:0] clr_mask;
	logic        [POS_W-1:0]   hi_pos;
	logic        [POS_W-1:0]   pos_s1;
	logic                      take_add;
	logic                      take_sub;
	abm_op_t                   op_s1;

	assign a_ext = PROD_W'(signed'(operand_a));
	assign b_ext = PROD_W'(signed'(operand_b));
	assign a_w   = a_ext[WIDTH_A-1:0];
	assign b_w   = b_ext[WIDTH_B-1:0];

	assign take_add = cmd.add_turn && (adds_q != '0);
	assign take_sub = !take_add && (subs_q != '0);
	assign sel_mask = take_add ? adds_q : subs_q;

	// highest set bit of the selected list
	always_comb begin
		hi_pos = '0;
		for (int i = 0; i < WIDTH_A; i++) begin
			if (sel_mask[i]) begin
				hi_pos = POS_W'(i);
			end
		end
	end

	assign clr_mask = ~(WIDTH_A'(1) << hi_pos);
	assign b_shift  = b_q << pos_s1;

	// selection stage: Booth lists and chosen position
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			adds_q <= ~a_w & (a_w << 1);
			subs_q <= a_w & ~(a_w << 1);
			b_q    <= PROD_W'(b_w);
		end else if (cmd.step) begin
			if (take_add) begin
				adds_q <= adds_q & clr_mask;
			end else if (take_sub) begin
				subs_q <= subs_q & clr_mask;
			end
		end
		pos_s1 <= hi_pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
		end else if (cmd.step && take_add) begin
			op_s1 <= OP_ADD;
		end else if (cmd.step && take_sub) begin
			op_s1 <= OP_SUB;
		end else begin
			op_s1 <= OP_NONE;
		end
	end

	// accumulate stage, wraps modulo 2^32
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= '0;
		end else begin
			unique case (op_s1)
				OP_ADD:  acc_q <= acc_q + b_shift;
				OP_SUB:  acc_q <= acc_q - b_shift;
				default: acc_q <= acc_q;
			endcase
		end
		if (cmd.capture) begin
			out_q <= acc_q;
		end
	end

	assign status.lists_empty = (adds_q == '0) && (subs_q == '0);
	assign approx_product     = out_q;

endmodule
`default_nettype wire

/* sv/abm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module abm_ctrl import abm_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [BUDGET_W-1:0] step_budget,
	input  wire logic                parity_flip,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output abm_cmd_t                 cmd,
	input  wire abm_status_t         status
);

	abm_state_t          state_q;
	abm_state_t          state_d;
	logic [BUDGET_W-1:0] step_q;
	logic                out_valid_q;
	logic                run_stop;
	logic                out_free;

	assign run_stop = (step_q == step_budget) || status.lists_empty;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (s_tvalid) state_d = S_RUN;
			S_RUN:   if (run_stop) state_d = S_DRAIN;
			S_DRAIN: state_d = S_HOLD;
			S_HOLD:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.add_turn = (step_q[0] ^ parity_flip) == 1'b0;
		s_tready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			S_RUN:   cmd.step = !run_stop;
			S_DRAIN: ;
			S_HOLD:  cmd.capture = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

	a_capture_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> (!out_valid_q || m_tready))
		else $error("result captured over an untaken result");

	a_valid_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_HOLD))
		else $error("result raised outside hold state");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_RUN && !out_valid_q == !$past(out_valid_q && !m_tready)))
		else $error("load did not start a run");

endmodule
`default_nettype wire

/* sv/approximate_booth_multiplier.sv */
`timescale 1ns / 1ps
`default_nettype none
// Each accepted item runs n steps before m_axis_tvalid, where n is the
// number of steps made: min(step_budget, steps until both Booth lists run out).
// An item is taken only once the last one is done; one shared add/subtract unit does one
// step a cycle (n <= 32 by default). A finished result waits in the output
// register while the next item is taken in.
// Reset (arst_n low, async): idle, no result pending, step_budget = 32, parity_flip = 0.
module approximate_booth_multiplier import abm_pkg::*; #(
	parameter int WIDTH_A = DEF_WIDTH_A,
	parameter int WIDTH_B = DEF_WIDTH_B
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [2*OPND_W-1:0]   s_axis_tdata,   // operand_a, operand_b
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [PROD_W-1:0]          m_axis_tdata,   // approx_product
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [BUDGET_W-1:0]   cfg_wdata
);

	logic [BUDGET_W-1:0] step_budget_q;
	logic                parity_flip_q;
	abm_cmd_t            cmd;
	abm_status_t         status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_budget_q <= BUDGET_RESET;
			parity_flip_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_STEP_BUDGET: step_budget_q <= cfg_wdata;
				REG_PARITY_FLIP: parity_flip_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	abm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_budget (step_budget_q),
		.parity_flip (parity_flip_q),
		.s_tvalid    (s_axis_tvalid),
		.s_tready    (s_axis_tready),
		.m_tvalid    (m_axis_tvalid),
		.m_tready    (m_axis_tready),
		.cmd         (cmd),
		.status      (status)
	);

	abm_datapath #(
		.WIDTH_A (WIDTH_A),
		.WIDTH_B (WIDTH_B)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.operand_a      (s_axis_tdata[OPND_W-1:0]),
		.operand_b      (s_axis_tdata[2*OPND_W-1:OPND_W]),
		.approx_product (m_axis_tdata)
	);

endmodule
`default_nettype wire

/* dv/product_checker.sv */
`timescale 1ns / 1ps
module product_checker import abm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	input  wire logic                  s_axis_tready,
	input  wire logic [2*OPND_W-1:0]   s_axis_tdata,   // operand_a, operand_b
	input  wire logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	input  wire logic [PROD_W-1:0]     m_axis_tdata,   // approx_product
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [BUDGET_W-1:0]   cfg_wdata,
	output int                         mismatches,
	output int                         outstanding
);

	typedef struct packed {
		logic signed [OPND_W-1:0] operand_b;
		logic signed [OPND_W-1:0] operand_a;
	} operands_t;

	logic [BUDGET_W-1:0] step_limit;
	logic                odd_adds;
	logic [PROD_W-1:0]   pending_products[$];

	function automatic int top_bit(input logic [OPND_W-1:0] bits);
		for (int i = OPND_W - 1; i >= 0; i--)
			if (bits[i])
				return i;
		return -1;
	endfunction

	// Booth transitions of a, taken highest first, adds on alternating turns
	function automatic logic [PROD_W-1:0] booth_product(input logic [OPND_W-1:0] a,
			input logic [OPND_W-1:0] b, input logic [BUDGET_W-1:0] steps,
			input logic flip);
		logic [OPND_W-1:0] add_bits;
		logic [OPND_W-1:0] sub_bits;
		logic [PROD_W-1:0] mcand;
		logic [PROD_W-1:0] acc;
		logic              adds_done;
		logic              subs_done;
		logic              took_add;
		int                pos;
		add_bits  = ~a & (a << 1);
		sub_bits  = a & ~(a << 1);
		mcand     = {{(PROD_W - OPND_W){b[OPND_W-1]}}, b};
		acc       = '0;
		adds_done = 1'b0;
		subs_done = 1'b0;
		for (int t = 0; t < int'(steps); t++) begin
			took_add = 1'b0;
			if (!adds_done && (((t + int'(flip)) & 1) == 0)) begin
				pos = top_bit(add_bits);
				if (pos >= 0) begin
					acc = acc + (mcand << pos);
					add_bits[pos] = 1'b0;
					took_add = 1'b1;
				end else
					adds_done = 1'b1;
			end
			if (!subs_done && !took_add) begin
				pos = top_bit(sub_bits);
				if (pos >= 0) begin
					acc = acc - (mcand << pos);
					sub_bits[pos] = 1'b0;
				end else
					subs_done = 1'b1;
			end
			if (adds_done && subs_done)
				break;
		end
		return acc;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		operands_t   ops;
		logic [PROD_W-1:0] want;
		if (!arst_n) begin
			step_limit = BUDGET_RESET;
			odd_adds   = 1'b0;
			pending_products.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				ops = s_axis_tdata;
				pending_products.push_back(booth_product(ops.operand_a, ops.operand_b,
					step_limit, odd_adds));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_products.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected product %h at %0t", m_axis_tdata, $realtime);
				end else begin
					want = pending_products.pop_front();
					if (m_axis_tdata !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("approx_product mismatch at %0t: expected %h (%0d) got %h (%0d)",
								$realtime, want, $signed(want), m_axis_tdata,
								$signed(m_axis_tdata));
					end
				end
			end
			// config applies from the next item on
			if (cfg_we) begin
				case (cfg_addr)
					REG_STEP_BUDGET: step_limit = cfg_wdata;
					REG_PARITY_FLIP: odd_adds = cfg_wdata[0];
					default: ;
				endcase
			end
			outstanding <= pending_products.size();
		end
	end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	import abm_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 70;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [2*OPND_W-1:0]   s_axis_tdata = '0;   // operand_a, operand_b
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [PROD_W-1:0]     m_axis_tdata;        // approx_product
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [BUDGET_W-1:0]   cfg_wdata = '0;

	int mismatches;
	int outstanding;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int idle_cycles = 0;
	bit long_hold = 1'b0;

	always #2 clk = ~clk;

	approximate_booth_multiplier DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	product_checker product_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// result side: random stalls, or one long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
				m_axis_tready <= 1'b1;
			end else
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [BUDGET_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [BUDGET_W-1:0] steps, input logic flip);
		write_reg(REG_STEP_BUDGET, steps);
		write_reg(REG_PARITY_FLIP, BUDGET_W'(flip));
	endtask

	task automatic push_item(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, a};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic end_burst();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		@(posedge clk);
		wait (outstanding == 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [OPND_W-1:0] pick_operand();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			4: return $urandom_range(1) ? 16'h5555 : 16'hAAAA;
			5: return OPND_W'(1) << $urandom_range(OPND_W - 1);
			default: return OPND_W'($urandom);
		endcase
	endfunction

	task automatic run_batch(input int count, input int idle_pct, input int stall);
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		repeat (count)
			push_item(pick_operand(), pick_operand());
		end_burst();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset config: budget 32, adds on even steps
		push_item(16'h0000, 16'h0000);
		push_item(16'h7FFF, 16'h7FFF);
		push_item(16'h8000, 16'h8000);
		push_item(16'h8000, 16'h7FFF);
		push_item(16'h7FFF, 16'h8000);
		push_item(16'hFFFF, 16'hFFFF);
		push_item(16'h0001, 16'hFFFF);
		push_item(16'hFFFF, 16'h0001);
		push_item(16'h5555, 16'h1234);
		push_item(16'hAAAA, 16'h8000);
		push_item(16'h5555, 16'h7FFF);
		push_item(16'h00F0, 16'hC001);
		push_item(16'h8001, 16'h8000);
		end_burst();
		run_batch(300, 0, 0);

		drain();
		set_config(6'd63, 1'b1);
		push_item(16'hAAAA, 16'h7FFF);
		push_item(16'h5555, 16'h8000);
		end_burst();
		run_batch(300, 70, 0);

		// zero budget: every product is zero
		drain();
		set_config(6'd0, 1'b0);
		run_batch(150, 0, 70);

		// coarse budgets; long receiver hold-off fills the block
		drain();
		set_config(6'($urandom_range(12, 1)), 1'($urandom_range(1)));
		long_hold = 1'b1;
		run_batch(350, 20, 20);

		drain();
		set_config(6'd1, 1'b1);
		run_batch(150, 0, 0);
		drain();
		run_batch(150, 0, 0);

		repeat (6) begin
			drain();
			set_config(6'($urandom_range(63)), 1'($urandom_range(1)));
			run_batch(80, 20, 20);
		end

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
